@@ hw/rtl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the Go-Back-N sender: field widths,
// operation codes, register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  // Buffer and window limits
  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned MAX_WINDOW = 16;

  // Field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SEQ_W    = 10;
  localparam int unsigned WSIZE_W  = 5;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned PTR_W    = 11;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned CFG_D_W  = 11;

  // Packed stream widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;

  // Saturation bounds for the configuration registers
  localparam logic [WSIZE_W-1:0] WSIZE_MAX = WSIZE_W'(MAX_WINDOW);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_FRAMES);

  // Operation codes carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 3'd0,
    OP_START   = 3'd1,
    OP_ACK     = 3'd2,
    OP_NACK    = 3'd3,
    OP_TIMEOUT = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IX_W-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_FRAME_COUNT = 2'd1
  } cfg_reg_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_SEND  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage : gbn_pkg

`default_nettype wire

@@ hw/rtl/go_back_n_sender.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N sender: frame buffer, sliding window and a small sequencer that
// walks the window through one memory read port, one frame word at a time.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  in_     | in  | in_tvalid/in_tready   | tuser op, tdata index/value/seq
//  out_    | out | out_tvalid/out_tready | tdata data/seq, tuser done, tlast
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  An item is taken in idle. A (re)transmission of w frames then steps
//  through a buffer read, then an output register load, for each frame,
//  bounded by the single buffer read port.
//  Output stalls hold the sequencer in its send step; input is not taken
//  until the last word of the item is in the output register.
//  rst_n is synchronous, active low; the frame buffer is not cleared.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender
  import gbn_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // load_index, load_value, ack_seq, pad
  input  wire logic [OP_W-1:0]        in_tuser,   // op
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // frame_data, frame_seq, pad
  output logic                        out_tuser,  // is_done
  output logic                        out_tlast,  // last
  // configuration
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IX_W-1:0]    cfg_index,
  input  wire logic [CFG_D_W-1:0]     cfg_data
);

  // Input field unpacking
  logic [IDX_W-1:0]  load_index;
  logic [DATA_W-1:0] load_value;
  logic [SEQ_W-1:0]  ack_seq;
  op_t               op;

  assign load_index = in_tdata[IDX_W-1:0];
  assign load_value = in_tdata[IDX_W+DATA_W-1:IDX_W];
  assign ack_seq    = in_tdata[IDX_W+DATA_W+SEQ_W-1:IDX_W+DATA_W];
  assign op         = op_t'(in_tuser);

  // Configuration registers
  logic [WSIZE_W-1:0] window_size_r;
  logic [COUNT_W-1:0] frame_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WSIZE_W'(1);
      frame_count_r <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SIZE: window_size_r <= cfg_data[WSIZE_W-1:0];
        REG_FRAME_COUNT: frame_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated register values
  logic [WSIZE_W-1:0] eff_size;
  logic [COUNT_W-1:0] eff_count;

  always_comb begin
    eff_size = window_size_r;
    if (window_size_r == '0)      eff_size = WSIZE_W'(1);
    if (window_size_r > WSIZE_MAX) eff_size = WSIZE_MAX;
    eff_count = frame_count_r;
    if (frame_count_r == '0)       eff_count = COUNT_W'(1);
    if (frame_count_r > COUNT_MAX) eff_count = COUNT_MAX;
  end

  // Sequencer state
  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   start_r, start_nxt;
  logic [PTR_W-1:0]   end_r, end_nxt;
  logic [PTR_W-1:0]   expect_r, expect_nxt;
  logic [PTR_W-1:0]   cur_r, cur_nxt;
  logic               running_r, running_nxt;
  logic               finished_r, finished_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [SEQ_W-1:0]   out_seq_r, out_seq_nxt;
  logic               out_done_r, out_done_nxt;
  logic               out_last_r, out_last_nxt;

  // Frame buffer, registered read
  logic [DATA_W-1:0]  mem [MAX_FRAMES];
  logic [DATA_W-1:0]  rd_data_r;
  logic               in_fire;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_fire && !finished_r && op == OP_LOAD) begin
      mem[load_index] <= load_value;
    end
    rd_data_r <= mem[cur_r[IDX_W-1:0]];
  end

  // Shared pointer incrementer and window bound compare
  logic [PTR_W-1:0] cur_inc;
  logic             more;
  logic             out_free;
  logic             win_open;

  assign cur_inc  = cur_r + PTR_W'(1);
  assign more     = (cur_inc <= end_r) && (cur_inc < eff_count);
  assign out_free = !out_valid_r || out_tready;
  // window start still inside the frame count, so a resend has a word
  assign win_open = (start_r < eff_count);

  // Next-state logic
  always_comb begin
    state_nxt    = state_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    expect_nxt   = expect_r;
    cur_nxt      = cur_r;
    running_nxt  = running_r;
    finished_nxt = finished_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_seq_nxt   = out_seq_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire && !finished_r) begin
          case (op)
            OP_START: begin
              start_nxt   = '0;
              end_nxt     = PTR_W'(eff_size) - PTR_W'(1);
              expect_nxt  = '0;
              running_nxt = 1'b1;
              cur_nxt     = '0;
              state_nxt   = ST_FETCH;
            end
            OP_ACK: begin
              if (running_r) begin
                if ({1'b0, ack_seq} > expect_r) begin
                  if (win_open) begin
                    cur_nxt   = start_r;
                    state_nxt = ST_FETCH;
                  end
                end else if (start_r + PTR_W'(1) >= eff_count) begin
                  // every frame acknowledged
                  start_nxt    = start_r + PTR_W'(1);
                  running_nxt  = 1'b0;
                  finished_nxt = 1'b1;
                  state_nxt    = ST_DONE;
                end else begin
                  // slide by one, send the newly admitted frame if it is inside the frame count
                  start_nxt  = start_r + PTR_W'(1);
                  end_nxt    = end_r + PTR_W'(1);
                  expect_nxt = {1'b0, ack_seq} + PTR_W'(1);
                  cur_nxt    = end_r + PTR_W'(1);
                  if (end_r + PTR_W'(1) < eff_count) begin
                    state_nxt = ST_FETCH;
                  end
                end
              end
            end
            OP_NACK, OP_TIMEOUT: begin
              if (running_r && win_open) begin
                cur_nxt   = start_r;
                state_nxt = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      // buffer read of cur_r happens at this edge
      ST_FETCH: begin
        state_nxt = ST_SEND;
      end

      // hand the frame word to the output register
      ST_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data_r;
          out_seq_nxt   = cur_r[SEQ_W-1:0];
          out_done_nxt  = 1'b0;
          out_last_nxt  = !more;
          if (more) begin
            cur_nxt   = cur_inc;
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      // completion word
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_seq_nxt   = '0;
          out_done_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      end_r       <= '0;
      expect_r    <= '0;
      cur_r       <= '0;
      running_r   <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      expect_r    <= expect_nxt;
      cur_r       <= cur_nxt;
      running_r   <= running_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_seq_r  <= out_seq_nxt;
    out_done_r <= out_done_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-DATA_W-SEQ_W)'(0), out_seq_r, out_data_r};
  assign out_tuser  = out_done_r;
  assign out_tlast  = out_last_r;

endmodule : go_back_n_sender

`default_nettype wire

@@ hw/rtl/gbn_checker.sv @@
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the Go-Back-N sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed under stall");

  // completion word carries no frame and closes the run
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 48'd0))
    else $error("malformed completion word");

  // nothing follows the completion word
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser |=> !out_tvalid)
    else $error("result after completion");

endmodule : gbn_checker

bind go_back_n_sender gbn_checker u_gbn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

@@ sim/tb_go_back_n_sender.sv @@
// ----------------------------------------------------------------------------
// tb_go_back_n_sender
// Self-checking bench for the Go-Back-N sender. Every frame that a run can
// reach is preloaded first. A short table then covers the idle and reset
// behaviour, the reserved ops and register saturation. Random phases follow,
// each with its own window and frame count, and end in a single run that goes
// on to completion. Every accepted word on the result stream is checked in
// order against a bench-side model of the window. Both streams idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_go_back_n_sender;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned IDLE_CYCLES  = 40;   // settle time before a register write
  localparam int unsigned DRAIN_CYCLES = 60;   // drain time once no word is owed
  localparam int unsigned HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned PHASE_ITEMS  = 14;
  localparam int unsigned NUM_PHASES   = 6;
  // a window of 16 slid by every phase item stays below this frame
  localparam int unsigned PRELOAD_FRAMES = 40;
  localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

  // op codes outside the defined set
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [SEQ_W-1:0]  seq;
    logic              done;
    logic              last;
  } frame_word_t;

  // how a table row is checked: by the model, no word at all, or one frame 0
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} chk_t;

  typedef struct {
    logic              is_cfg;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic [SEQ_W-1:0]  seq;
    cfg_reg_t          reg_ix;
    logic [CFG_D_W-1:0] reg_val;
    chk_t              chk;
    logic [DATA_W-1:0] exp_data;
  } dir_row_t;

  // DUT connections
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // load_index, load_value, ack_seq, pad
  logic [OP_W-1:0]        in_tuser = '0;   // op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // frame_data, frame_seq, pad
  logic                   out_tuser;       // is_done
  logic                   out_tlast;       // last
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IX_W-1:0]    cfg_index = '0;
  logic [CFG_D_W-1:0]     cfg_data = '0;

  // window model state
  logic [DATA_W-1:0]  frame_mem [MAX_FRAMES];
  logic [PTR_W-1:0]   win_lo = '0;
  logic [PTR_W-1:0]   win_hi = '0;
  logic [PTR_W-1:0]   ack_next = '0;
  logic               link_up = 1'b0;
  logic               link_done = 1'b0;
  logic [WSIZE_W-1:0] wsize_reg = WSIZE_W'(1);
  logic [COUNT_W-1:0] fcount_reg = COUNT_W'(1);

  frame_word_t frames_due[$];   // words still owed by the block, oldest first
  frame_word_t new_frames[$];   // words caused by the item just taken
  dir_row_t    dir_rows[$];
  int unsigned n_bad = 0;
  int unsigned n_frames = 0;
  logic        tx_calm = 1'b0;

  go_back_n_sender u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // registers as used, saturated into range
  function automatic logic [PTR_W-1:0] win_len();
    if (wsize_reg == '0) return PTR_W'(1);
    if (wsize_reg > WSIZE_MAX) return PTR_W'(WSIZE_MAX);
    return PTR_W'(wsize_reg);
  endfunction

  function automatic logic [PTR_W-1:0] frames_total();
    if (fcount_reg == '0) return PTR_W'(1);
    if (fcount_reg > COUNT_MAX) return PTR_W'(COUNT_MAX);
    return PTR_W'(fcount_reg);
  endfunction

  // whole window, capped at the frame count and at MAX_WINDOW words
  function automatic void resend_window();
    logic [PTR_W-1:0] i;
    int unsigned k;
    logic lst;
    i = win_lo;
    k = 0;
    while (i <= win_hi && i < frames_total() && k < MAX_WINDOW) begin
      lst = (i == win_hi) || (i + 1'b1 == frames_total()) || (k == MAX_WINDOW - 1);
      new_frames.push_back('{frame_mem[i], i[SEQ_W-1:0], 1'b0, lst});
      i++;
      k++;
    end
  endfunction

  // advance the window model by one taken item, collecting its words
  function automatic void predict_frames(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                         logic [DATA_W-1:0] val, logic [SEQ_W-1:0] seq);
    new_frames.delete();
    if (link_done) return;
    case (op)
      OP_LOAD: frame_mem[idx] = val;
      OP_START: begin
        win_lo   = '0;
        win_hi   = win_len() - 1'b1;
        ack_next = '0;
        link_up  = 1'b1;
        resend_window();
      end
      OP_ACK: begin
        if (link_up) begin
          if ({1'b0, seq} > ack_next) begin
            resend_window();
          end else begin
            // ack at or below expected slides the window by one
            win_lo++;
            if (win_lo >= frames_total()) begin
              link_up   = 1'b0;
              link_done = 1'b1;
              new_frames.push_back('{'0, '0, 1'b1, 1'b1});
            end else begin
              win_hi++;
              ack_next = {1'b0, seq} + 1'b1;
              if (win_hi < frames_total())
                new_frames.push_back('{frame_mem[win_hi], win_hi[SEQ_W-1:0], 1'b0, 1'b1});
            end
          end
        end
      end
      OP_NACK, OP_TIMEOUT: if (link_up) resend_window();
      default: ;
    endcase
  endfunction

  // an ack with this seq would complete the run
  function automatic logic ack_closes(logic [SEQ_W-1:0] seq);
    return link_up && ({1'b0, seq} <= ack_next) && (win_lo + 1'b1 >= frames_total());
  endfunction

  // idle gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap(logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void dir_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                   logic [DATA_W-1:0] val, logic [SEQ_W-1:0] seq,
                                   chk_t chk, logic [DATA_W-1:0] exp_data);
    dir_rows.push_back('{is_cfg: 1'b0, op: op, idx: idx, val: val, seq: seq,
                         reg_ix: REG_WINDOW_SIZE, reg_val: '0, chk: chk,
                         exp_data: exp_data});
  endfunction

  function automatic void dir_cfg(cfg_reg_t ix, logic [CFG_D_W-1:0] value);
    dir_rows.push_back('{is_cfg: 1'b1, op: OP_LOAD, idx: '0, val: '0, seq: '0,
                         reg_ix: ix, reg_val: value, chk: CHK_NONE, exp_data: '0});
  endfunction

  // offer one input word and book what it should cause
  task automatic send_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [DATA_W-1:0] val, logic [SEQ_W-1:0] seq,
                           chk_t chk, logic [DATA_W-1:0] exp_data);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({seq, val, idx});
    do @(posedge clk); while (!in_tready);
    predict_frames(op, idx, val, seq);
    case (chk)
      CHK_PREDICT: foreach (new_frames[i]) frames_due.push_back(new_frames[i]);
      CHK_ONE:     frames_due.push_back('{exp_data, '0, 1'b0, 1'b1});
      default: ;
    endcase
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(cfg_reg_t ix, logic [CFG_D_W-1:0] value);
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (ix == REG_WINDOW_SIZE) wsize_reg = value[WSIZE_W-1:0];
    else fcount_reg = value[COUNT_W-1:0];
  endtask

  // random item, mostly acks, most of them in order; completion is held back to the last phase
  task automatic random_word(logic last_phase);
    logic [OP_W-1:0]   op;
    logic [SEQ_W-1:0]  seq;
    int unsigned       r;
    int unsigned       ack_share;
    seq = SEQ_W'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    ack_share = last_phase ? 75 : 55;
    if (r < ack_share) begin
      op = OP_ACK;
      r = $urandom_range(0, 9);
      if (r < 7) seq = ack_next[SEQ_W-1:0];
      else if (r < 9 && ack_next != '0) seq = SEQ_W'($urandom_range(0, ack_next - 1));
    end else if (r < ack_share + 10) op = OP_NACK;
    else if (r < ack_share + 18) op = OP_TIMEOUT;
    else if (r < ack_share + 28 && !last_phase) op = OP_LOAD;
    else if (r < ack_share + 33 && !last_phase) op = OP_START;
    else begin
      case ($urandom_range(0, 2))
        0: op = OP_RSVD_5;
        1: op = OP_RSVD_6;
        default: op = OP_RSVD_7;
      endcase
    end
    if (op == OP_ACK && !last_phase && ack_closes(seq)) begin
      if (ack_next < 1023) seq = SEQ_W'($urandom_range(ack_next + 1, 1023));
      else op = OP_TIMEOUT;
    end
    send_word(op, IDX_W'($urandom_range(0, MAX_FRAMES - 1)), $urandom, seq, CHK_PREDICT, '0);
  endtask

  // result side: check each word, stall at random, a long hold-off twice
  initial begin
    frame_word_t got;
    frame_word_t want;
    int unsigned hold;
    int unsigned n_press;
    logic        calm;
    hold = 0;
    n_press = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = '{out_tdata[DATA_W-1:0], out_tdata[DATA_W +: SEQ_W], out_tuser, out_tlast};
        n_frames++;
        if (frames_due.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN)
            $display("unexpected word: data %h seq %0d done %b last %b",
                     got.data, got.seq, got.done, got.last);
        end else begin
          want = frames_due.pop_front();
          if (got.data !== want.data || got.seq !== want.seq ||
              got.done !== want.done || got.last !== want.last) begin
            n_bad++;
            if (n_bad <= MAX_SHOWN)
              $display("word %0d: exp data %h seq %0d done %b last %b, got data %h seq %0d done %b last %b",
                       n_frames, want.data, want.seq, want.done, want.last,
                       got.data, got.seq, got.done, got.last);
          end
        end
      end
      if (hold == 0) begin
        if ((n_press == 0 && n_frames >= 20) || (n_press == 1 && n_frames >= 300)) begin
          hold = HOLD_CYCLES;
          n_press++;
        end else begin
          hold = pick_gap(calm);
        end
        if ($urandom_range(0, 63) == 0) calm = !calm;
      end
      if (rst_n && hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= rst_n;
      end
    end
  end

  // stimulus
  initial begin
    logic [WSIZE_W-1:0] ph_wsize [NUM_PHASES];
    logic [COUNT_W-1:0] ph_count [NUM_PHASES];
    int unsigned i;

    // random phases, out-of-range values included
    ph_wsize = '{5'd3, 5'd16, 5'd1,  5'd31, 5'd0,    5'd7};
    ph_count = '{11'd0, 11'd1024, 11'd2, 11'd40, 11'h7FF, 11'd12};

    // before start, at reset settings: one frame, one-frame window
    dir_item(OP_ACK,     10'd0,   32'd0,          10'd0,   CHK_NONE, '0);
    dir_item(OP_NACK,    10'd0,   32'd0,          10'h3FF, CHK_NONE, '0);
    dir_item(OP_TIMEOUT, 10'd0,   32'd0,          10'd0,   CHK_NONE, '0);
    dir_item(OP_LOAD,    10'd0,   32'h8000_0000,  10'd0,   CHK_NONE, '0);
    dir_item(OP_LOAD,    10'h3FF, 32'h7FFF_FFFF,  10'h3FF, CHK_NONE, '0);
    dir_item(OP_RSVD_5,  10'h3FF, 32'hFFFF_FFFF,  10'h3FF, CHK_NONE, '0);
    dir_item(OP_RSVD_6,  10'h155, 32'h5555_5555,  10'h2AA, CHK_NONE, '0);
    dir_item(OP_RSVD_7,  10'h2AA, 32'hAAAA_AAAA,  10'h155, CHK_NONE, '0);
    // running: every retransmission is frame 0 alone
    dir_item(OP_START,   10'd0,   32'd0,          10'd0,   CHK_ONE, 32'h8000_0000);
    dir_item(OP_NACK,    10'd0,   32'd0,          10'h3FF, CHK_ONE, 32'h8000_0000);
    dir_item(OP_TIMEOUT, 10'd0,   32'd0,          10'd0,   CHK_ONE, 32'h8000_0000);
    dir_item(OP_ACK,     10'd0,   32'd0,          10'h3FF, CHK_ONE, 32'h8000_0000);
    dir_item(OP_START,   10'd0,   32'd0,          10'd0,   CHK_ONE, 32'h8000_0000);
    dir_cfg(REG_WINDOW_SIZE, 11'd0);
    dir_item(OP_TIMEOUT, 10'd0,   32'd0,          10'd0,   CHK_ONE, 32'h8000_0000);
    // saturated maxima: 16-frame window over 1024 frames
    dir_cfg(REG_FRAME_COUNT, 11'h7FF);
    dir_cfg(REG_WINDOW_SIZE, 11'd31);
    dir_item(OP_START,   10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);
    dir_item(OP_ACK,     10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);
    dir_item(OP_ACK,     10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);
    dir_item(OP_LOAD,    10'd20,  32'h0000_0001,  10'd0,   CHK_PREDICT, '0);
    dir_item(OP_NACK,    10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);
    // window running past the last frame
    dir_cfg(REG_FRAME_COUNT, 11'd5);
    dir_cfg(REG_WINDOW_SIZE, 11'd4);
    dir_item(OP_START,   10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);
    dir_item(OP_ACK,     10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);
    dir_item(OP_ACK,     10'd0,   32'd0,          10'd1,   CHK_PREDICT, '0);
    dir_item(OP_TIMEOUT, 10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);
    dir_item(OP_ACK,     10'd0,   32'd0,          10'd2,   CHK_PREDICT, '0);
    dir_item(OP_NACK,    10'd0,   32'd0,          10'd0,   CHK_PREDICT, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every frame a run can reach so no unwritten entry is ever read
    for (i = 0; i < PRELOAD_FRAMES; i++)
      send_word(OP_LOAD, IDX_W'(i), $urandom, SEQ_W'($urandom_range(0, 1023)),
                CHK_PREDICT, '0);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg)
        write_reg(dir_rows[r].reg_ix, dir_rows[r].reg_val);
      else
        send_word(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].seq,
                  dir_rows[r].chk, dir_rows[r].exp_data);
    end

    for (i = 0; i < NUM_PHASES; i++) begin
      write_reg(REG_WINDOW_SIZE, CFG_D_W'(ph_wsize[i]));
      write_reg(REG_FRAME_COUNT, CFG_D_W'(ph_count[i]));
      send_word(OP_START, '0, '0, '0, CHK_PREDICT, '0);
      repeat (PHASE_ITEMS) random_word(1'b0);
    end

    // last run goes to completion, then a few words that must be ignored
    write_reg(REG_WINDOW_SIZE, CFG_D_W'($urandom_range(1, 16)));
    write_reg(REG_FRAME_COUNT, CFG_D_W'($urandom_range(2, 8)));
    send_word(OP_START, '0, '0, '0, CHK_PREDICT, '0);
    while (!link_done) random_word(1'b1);
    repeat (4) random_word(1'b1);
    send_word(OP_START, '0, '0, '0, CHK_PREDICT, '0);
    in_tvalid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_bad == 0 && frames_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule : tb_go_back_n_sender

`default_nettype wire

@@ go_back_n_sender.f @@
hw/rtl/gbn_pkg.sv
hw/rtl/go_back_n_sender.sv
hw/rtl/gbn_checker.sv
sim/tb_go_back_n_sender.sv
